// File: rtl/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page region splitter package
// Payload types, page size codes and address constants shared by the
// channel interfaces and the splitter logic.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int PHYS_ADDR_BITS = 52;
    localparam int LENGTH_BITS    = 48;
    // The rounded length can reach 2^LENGTH_BITS, so it needs one more bit.
    localparam int LEFT_W         = LENGTH_BITS + 1;
    localparam int ADD_W          = 64;
    localparam int COUNT_W        = 19;
    localparam int MAX_BATCHES    = 5;
    localparam int BATCH_IDX_W    = $clog2(MAX_BATCHES);

    localparam int SHIFT_4K = 12;
    localparam int SHIFT_2M = 21;
    localparam int SHIFT_1G = 30;

    localparam logic [ADD_W-1:0] PAGE_4K = ADD_W'(1) << SHIFT_4K;
    localparam logic [ADD_W-1:0] PAGE_2M = ADD_W'(1) << SHIFT_2M;
    localparam logic [ADD_W-1:0] PAGE_1G = ADD_W'(1) << SHIFT_1G;

    typedef enum logic [1:0] {
        SIZE_4K = 2'd0,
        SIZE_2M = 2'd1,
        SIZE_1G = 2'd2
    } page_size_t;

    typedef struct packed {
        logic [63:0]               start_virt;
        logic [PHYS_ADDR_BITS-1:0] start_phys;
        logic [LENGTH_BITS-1:0]    region_length;
        logic [3:0]                access_flags;
        logic [2:0]                cache_mode;
    } region_t;

    typedef struct packed {
        logic [63:0]               batch_virt;
        logic [PHYS_ADDR_BITS-1:0] batch_phys;
        logic [COUNT_W-1:0]        page_count;
        logic [1:0]                page_size_code;
        logic [3:0]                batch_flags;
        logic [2:0]                batch_cache;
        logic                      last_batch;
    } batch_t;

endpackage

// File: rtl/prs_region_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region channel
// Valid/ready channel that carries one memory region per beat.
// ----------------------------------------------------------------------------
interface prs_region_if;

    logic              valid;
    logic              ready;
    prs_pkg::region_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/prs_batch_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batch channel
// Valid/ready channel that carries one batch of equal pages per beat.
// ----------------------------------------------------------------------------
interface prs_batch_if;

    logic             valid;
    logic             ready;
    prs_pkg::batch_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/page_region_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page region splitter
// Splits one region into up to five batches of equal 4 KiB, 2 MiB or 1 GiB
// pages, chosen greedily from the physical alignment.
// ----------------------------------------------------------------------------
// A region beat is taken only while the splitter is idle. A rounding step
// first rounds the length up to 4 KiB; each batch then passes through five
// steps (size choice, output load, then length, physical and virtual update
// through the single shared 64-bit adder). The input stays closed until the
// last batch of a region has been through these steps, and the output load
// waits while the previous batch beat has not been taken. A zero-length region
// yields no batch and returns the splitter to idle after the rounding step.
// Batch beats sit in an output register, so the next region may start while
// the final batch still waits.
module page_region_splitter (
    input  logic              clk,
    input  logic              rst_n,
    prs_region_if.sink        region,
    prs_batch_if.source       batch
);

    localparam int LW = prs_pkg::LEFT_W;
    localparam int PW = prs_pkg::PHYS_ADDR_BITS;
    localparam int AW = prs_pkg::ADD_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ROUND = 7'b0000010,
        ST_PICK  = 7'b0000100,
        ST_EMIT  = 7'b0001000,
        ST_LEFT  = 7'b0010000,
        ST_PHYS  = 7'b0100000,
        ST_VIRT  = 7'b1000000
    } state_t;

    state_t                              state_reg, state_next;
    logic [prs_pkg::BATCH_IDX_W-1:0]     idx_reg, idx_next;
    logic                                out_valid_reg, out_valid_next;

    logic [63:0]                         virt_reg;
    logic [PW-1:0]                       phys_reg;
    logic [LW-1:0]                       left_reg;
    logic [LW-1:0]                       span_reg;
    logic [prs_pkg::COUNT_W-1:0]         count_reg;
    logic [1:0]                          code_reg;
    logic [3:0]                          flags_reg;
    logic [2:0]                          cache_reg;
    prs_pkg::batch_t                     out_data_reg;

    logic [AW-1:0]                       add_a, add_b, add_sum;
    logic                                add_cin;

    logic                                accept;
    logic                                load_out;
    logic                                is_last;
    logic [LW-1:0]                       left_rounded;

    logic [29:0]                         off_1g;
    logic [20:0]                         off_2m;
    logic [30:0]                         span_to_1g;
    logic [21:0]                         span_to_2m;
    logic [LW-1:0]                       clamp_2m, clamp_4k;
    logic                                fit_1g, fit_2m;
    logic [AW-1:0]                       cnt_1g, cnt_2m, cnt_4k;
    logic [LW-1:0]                       span_pick;
    logic [prs_pkg::COUNT_W-1:0]         count_pick;
    logic [1:0]                          code_pick;

    prs_adder u_adder (
        .op_a     (add_a),
        .op_b     (add_b),
        .carry_in (add_cin),
        .sum      (add_sum)
    );

    assign accept       = region.valid && region.ready;
    assign region.ready = (state_reg == ST_IDLE);
    assign batch.valid  = out_valid_reg;
    assign batch.data   = out_data_reg;

    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || batch.ready);
    // A batch that advances nothing leaves the state as it was, so the
    // batch limit has to end the region as well.
    assign is_last  = (span_reg == left_reg)
                      || (idx_reg == prs_pkg::BATCH_IDX_W'(prs_pkg::MAX_BATCHES - 1));

    assign left_rounded = add_sum[LW-1:0] & ~LW'(prs_pkg::PAGE_4K - 1);

    // Adder operand selection.
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            ST_ROUND:
            begin
                add_a = AW'(left_reg);
                add_b = prs_pkg::PAGE_4K - 1;
            end
            ST_LEFT:
            begin
                add_a   = AW'(left_reg);
                add_b   = ~AW'(span_reg);
                add_cin = 1'b1;
            end
            ST_PHYS:
            begin
                add_a = AW'(phys_reg);
                add_b = AW'(span_reg);
            end
            ST_VIRT:
            begin
                add_a = virt_reg;
                add_b = AW'(span_reg);
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
    end

    // Page size choice for the next batch.
    always_comb
    begin
        off_1g     = phys_reg[29:0];
        off_2m     = phys_reg[20:0];
        span_to_1g = 31'(prs_pkg::PAGE_1G) - 31'(off_1g);
        span_to_2m = 22'(prs_pkg::PAGE_2M) - 22'(off_2m);
        clamp_2m   = (LW'(span_to_1g) > left_reg) ? left_reg : LW'(span_to_1g);
        clamp_4k   = (LW'(span_to_2m) > left_reg) ? left_reg : LW'(span_to_2m);
        fit_1g     = (left_reg >= LW'(prs_pkg::PAGE_1G)) && (off_1g == '0);
        fit_2m     = (left_reg >= LW'(prs_pkg::PAGE_2M)) && (off_2m == '0);
        cnt_1g     = AW'(left_reg >> prs_pkg::SHIFT_1G);
        cnt_2m     = AW'(clamp_2m >> prs_pkg::SHIFT_2M);
        cnt_4k     = AW'(clamp_4k >> prs_pkg::SHIFT_4K);
        if (fit_1g)
        begin
            span_pick  = left_reg & ~LW'(prs_pkg::PAGE_1G - 1);
            count_pick = cnt_1g[prs_pkg::COUNT_W-1:0];
            code_pick  = prs_pkg::SIZE_1G;
        end
        else if (fit_2m)
        begin
            span_pick  = clamp_2m & ~LW'(prs_pkg::PAGE_2M - 1);
            count_pick = cnt_2m[prs_pkg::COUNT_W-1:0];
            code_pick  = prs_pkg::SIZE_2M;
        end
        else
        begin
            span_pick  = clamp_4k & ~LW'(prs_pkg::PAGE_4K - 1);
            count_pick = cnt_4k[prs_pkg::COUNT_W-1:0];
            code_pick  = prs_pkg::SIZE_4K;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (batch.valid && batch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ROUND;
                    idx_next   = '0;
                end
            end
            ST_ROUND:
            begin
                state_next = (left_rounded == '0) ? ST_IDLE : ST_PICK;
            end
            ST_PICK:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT:
            begin
                state_next = ST_PHYS;
            end
            ST_PHYS:
            begin
                state_next = ST_VIRT;
            end
            ST_VIRT:
            begin
                if (out_data_reg.last_batch)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PICK;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            virt_reg  <= region.data.start_virt;
            phys_reg  <= region.data.start_phys;
            left_reg  <= LW'(region.data.region_length);
            flags_reg <= region.data.access_flags;
            cache_reg <= region.data.cache_mode;
        end
        if (state_reg == ST_ROUND)
        begin
            left_reg <= left_rounded;
        end
        if (state_reg == ST_PICK)
        begin
            span_reg  <= span_pick;
            count_reg <= count_pick;
            code_reg  <= code_pick;
        end
        if (state_reg == ST_LEFT)
        begin
            left_reg <= add_sum[LW-1:0];
        end
        if (state_reg == ST_PHYS)
        begin
            phys_reg <= add_sum[PW-1:0];
        end
        if (state_reg == ST_VIRT)
        begin
            virt_reg <= add_sum;
        end
        if (load_out)
        begin
            out_data_reg.batch_virt     <= virt_reg;
            out_data_reg.batch_phys     <= phys_reg;
            out_data_reg.page_count     <= count_reg;
            out_data_reg.page_size_code <= code_reg;
            out_data_reg.batch_flags    <= flags_reg;
            out_data_reg.batch_cache    <= cache_reg;
            out_data_reg.last_batch     <= is_last;
        end
    end

    // A waiting batch beat must hold the sequencer at the output load.
    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && !batch.ready) |=> (state_reg == ST_EMIT))
        else $error("sequencer left the output load while a batch beat was pending");

    // The chosen span never exceeds what is left of the region.
    a_span_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |=> (span_reg <= left_reg))
        else $error("batch span larger than remaining length");

    a_batch_limit: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= prs_pkg::BATCH_IDX_W'(prs_pkg::MAX_BATCHES - 1))
        else $error("batch index beyond the batch limit");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

// File: rtl/prs_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared adder
// One 64-bit adder with carry in, time-shared by the splitter sequencer for
// rounding, length subtraction and address advance.
// ----------------------------------------------------------------------------
module prs_adder (
    input  logic [prs_pkg::ADD_W-1:0] op_a,
    input  logic [prs_pkg::ADD_W-1:0] op_b,
    input  logic                      carry_in,
    output logic [prs_pkg::ADD_W-1:0] sum
);

    assign sum = op_a + op_b + prs_pkg::ADD_W'(carry_in);

endmodule
